// ===== rtl/assert_macros.svh =====
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that is switched off while rst is high.
`define TSA_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property that is also checked across reset.
`define TSA_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/tsa_pkg.sv =====
package tsa_pkg;

   // Micro tile geometry
   localparam int TILE_DIM        = 8;
   localparam int TILE_SHIFT      = $clog2(TILE_DIM);
   localparam int TILE_AREA_SHIFT = 2 * TILE_SHIFT;
   localparam int COORD_BITS_DEF  = 14;

   // Field widths
   localparam int EB_W      = 5;
   localparam int PITCH_W   = 18;
   localparam int GROUP_W   = 11;
   localparam int CHAN_W    = 4;
   localparam int BANK_W    = 4;
   localparam int LOG_W     = 4;
   localparam int EB_LOG_W  = 3;
   localparam int SEL_LOG_W = 2;
   localparam int OFF_W     = 32;
   localparam int PN_W      = 6;
   localparam int SWZ_W     = 3;
   localparam int ELEM_OFF_W   = 11;
   localparam int TILE_BYTES_W = EB_W + TILE_AREA_SHIFT;
   localparam int PERROW_W     = PITCH_W - TILE_SHIFT;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = PITCH_W;

   // Stencil bytes precede the depth plane inside a 4-byte depth tile
   localparam int STENCIL_PLANE_BYTES = 64;

   // Element sizes with a defined in-tile layout
   localparam logic [EB_W-1:0] EB_1  = 5'd1;
   localparam logic [EB_W-1:0] EB_2  = 5'd2;
   localparam logic [EB_W-1:0] EB_4  = 5'd4;
   localparam logic [EB_W-1:0] EB_8  = 5'd8;
   localparam logic [EB_W-1:0] EB_16 = 5'd16;

   localparam logic [CHAN_W-1:0] CH_4 = 4'd4;
   localparam logic [CHAN_W-1:0] CH_8 = 4'd8;
   localparam logic [BANK_W-1:0] BK_4 = 4'd4;
   localparam logic [BANK_W-1:0] BK_8 = 4'd8;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TILE_MODE        = 3'd0,
      CSR_ELEM_SIZE        = 3'd1,
      CSR_PITCH_BYTES      = 3'd2,
      CSR_GROUP_BYTES      = 3'd3,
      CSR_CHAN_COUNT       = 3'd4,
      CSR_BANK_COUNT       = 3'd5,
      CSR_ALT_BANK_SWIZZLE = 3'd6
   } csr_index_type;

   // index of the highest set bit, zero for zero
   function automatic logic [LOG_W-1:0] floor_log2(input logic [GROUP_W-1:0] v);
      logic [LOG_W-1:0] r;
      r = '0;
      for (int i = 1; i < GROUP_W; i++) begin
         if (v[i]) r = LOG_W'(i);
      end
      return r;
   endfunction

   // Reset values
   localparam logic                RST_TILE_MODE   = 1'b1;
   localparam logic [EB_W-1:0]     RST_ELEM_BYTES  = 5'd4;
   localparam logic [PITCH_W-1:0]  RST_PITCH_BYTES = 18'd4096;
   localparam logic [GROUP_W-1:0]  RST_GROUP_BYTES = 11'd256;
   localparam logic [CHAN_W-1:0]   RST_NUM_CHAN    = 4'd2;
   localparam logic [BANK_W-1:0]   RST_NUM_BANKS   = 4'd4;
   localparam logic                RST_ALT_SWZ     = 1'b0;

   // Configuration with the log2 of each size kept next to it
   typedef struct packed {
      logic                  tile_mode;
      logic [EB_W-1:0]       elem_size;
      logic [EB_LOG_W-1:0]   eb_log;
      logic [PITCH_W-1:0]    pitch_bytes;
      logic [LOG_W-1:0]      gbits;
      logic [CHAN_W-1:0]     chan_count;
      logic [SEL_LOG_W-1:0]  cbits;
      logic [BANK_W-1:0]     bank_count;
      logic [SEL_LOG_W-1:0]  bbits;
      logic                  alt_bank_swizzle;
   } cfg_type;

   // Per-item data that travels beside the tile index
   typedef struct packed {
      logic [ELEM_OFF_W-1:0] elem_off;
      logic [SWZ_W-1:0]      channel;
      logic [SWZ_W-1:0]      bank;
   } place_type;

endpackage

// ===== rtl/tsa_if.sv =====
interface tsa_req_if #(parameter int COORD_BITS = tsa_pkg::COORD_BITS_DEF) ();
   logic                  valid;
   logic                  ready;
   logic [COORD_BITS-1:0] pixel_x;
   logic [COORD_BITS-1:0] pixel_y;
   logic                  depth_surface;
   logic                  stencil_plane;

   modport source (output valid, pixel_x, pixel_y, depth_surface, stencil_plane, input ready);
   modport sink   (input valid, pixel_x, pixel_y, depth_surface, stencil_plane, output ready);
endinterface

interface tsa_rsp_if ();
   logic                       valid;
   logic                       ready;
   logic [tsa_pkg::OFF_W-1:0]  byte_offset;

   modport source (output valid, byte_offset, input ready);
   modport sink   (input valid, byte_offset, output ready);
endinterface

// ===== rtl/tsa_csr.sv =====
module tsa_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [tsa_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [tsa_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output tsa_pkg::cfg_type                 cfg
);

   tsa_pkg::cfg_type cfg_ff;
   tsa_pkg::cfg_type cfg_in;
   tsa_pkg::cfg_type cfg_rst;

   always_comb begin
      cfg_rst = '0;
      cfg_rst.tile_mode        = tsa_pkg::RST_TILE_MODE;
      cfg_rst.elem_size        = tsa_pkg::RST_ELEM_BYTES;
      cfg_rst.eb_log           = tsa_pkg::EB_LOG_W'(tsa_pkg::floor_log2(
                                    tsa_pkg::GROUP_W'(tsa_pkg::RST_ELEM_BYTES)));
      cfg_rst.pitch_bytes      = tsa_pkg::RST_PITCH_BYTES;
      cfg_rst.gbits            = tsa_pkg::floor_log2(tsa_pkg::RST_GROUP_BYTES);
      cfg_rst.chan_count       = tsa_pkg::RST_NUM_CHAN;
      cfg_rst.cbits            = tsa_pkg::SEL_LOG_W'(tsa_pkg::floor_log2(
                                    tsa_pkg::GROUP_W'(tsa_pkg::RST_NUM_CHAN)));
      cfg_rst.bank_count       = tsa_pkg::RST_NUM_BANKS;
      cfg_rst.bbits            = tsa_pkg::SEL_LOG_W'(tsa_pkg::floor_log2(
                                    tsa_pkg::GROUP_W'(tsa_pkg::RST_NUM_BANKS)));
      cfg_rst.alt_bank_swizzle = tsa_pkg::RST_ALT_SWZ;
   end

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (tsa_pkg::csr_index_type'(csr_index))
            tsa_pkg::CSR_TILE_MODE: begin
               cfg_in.tile_mode = csr_wdata[0];
            end
            tsa_pkg::CSR_ELEM_SIZE: begin
               cfg_in.elem_size = csr_wdata[tsa_pkg::EB_W-1:0];
               cfg_in.eb_log = tsa_pkg::EB_LOG_W'(tsa_pkg::floor_log2(
                                  tsa_pkg::GROUP_W'(csr_wdata[tsa_pkg::EB_W-1:0])));
            end
            tsa_pkg::CSR_PITCH_BYTES: begin
               cfg_in.pitch_bytes = csr_wdata[tsa_pkg::PITCH_W-1:0];
            end
            tsa_pkg::CSR_GROUP_BYTES: begin
               cfg_in.gbits = tsa_pkg::floor_log2(csr_wdata[tsa_pkg::GROUP_W-1:0]);
            end
            tsa_pkg::CSR_CHAN_COUNT: begin
               cfg_in.chan_count = csr_wdata[tsa_pkg::CHAN_W-1:0];
               cfg_in.cbits = tsa_pkg::SEL_LOG_W'(tsa_pkg::floor_log2(
                                 tsa_pkg::GROUP_W'(csr_wdata[tsa_pkg::CHAN_W-1:0])));
            end
            tsa_pkg::CSR_BANK_COUNT: begin
               cfg_in.bank_count = csr_wdata[tsa_pkg::BANK_W-1:0];
               cfg_in.bbits = tsa_pkg::SEL_LOG_W'(tsa_pkg::floor_log2(
                                 tsa_pkg::GROUP_W'(csr_wdata[tsa_pkg::BANK_W-1:0])));
            end
            tsa_pkg::CSR_ALT_BANK_SWIZZLE: begin
               cfg_in.alt_bank_swizzle = csr_wdata[0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= cfg_rst;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== rtl/tsa_geom.sv =====
// Tile index, in-tile byte offset and channel/bank swizzle for one item.
module tsa_geom #(
   parameter int COORD_BITS = tsa_pkg::COORD_BITS_DEF
) (
   input  tsa_pkg::cfg_type     cfg,
   input  logic [COORD_BITS-1:0] pixel_x,
   input  logic [COORD_BITS-1:0] pixel_y,
   input  logic                  depth_surface,
   input  logic                  stencil_plane,
   output logic [COORD_BITS-tsa_pkg::TILE_SHIFT+tsa_pkg::PERROW_W:0] tile_index,
   output tsa_pkg::place_type    place
);

   localparam int TC_W   = COORD_BITS - tsa_pkg::TILE_SHIFT;
   localparam int PROD_W = TC_W + tsa_pkg::PERROW_W;
   localparam int IDX_W  = PROD_W + 1;

   logic [TC_W-1:0]              tile_x, tile_y, row, col;
   logic [tsa_pkg::PITCH_W-1:0]  pitch_elems;
   logic [tsa_pkg::PERROW_W-1:0] pitch_tiles, per_row;
   logic [PROD_W-1:0]            row_prod;
   logic [COORD_BITS-1:0]        y_sh;
   logic [tsa_pkg::PN_W-1:0]     pn_depth, pn_color;
   logic [tsa_pkg::ELEM_OFF_W-1:0] color_off, depth_off, dz, elem_off;
   logic [tsa_pkg::SWZ_W-1:0]    chan_sel, bank_sel;
   logic                         alt4, alt8;

   // Row and column in tiles (1D) or macro tiles (2D)
   always_comb begin
      tile_x      = pixel_x[COORD_BITS-1:tsa_pkg::TILE_SHIFT];
      tile_y      = pixel_y[COORD_BITS-1:tsa_pkg::TILE_SHIFT];
      pitch_elems = cfg.pitch_bytes >> cfg.eb_log;
      pitch_tiles = pitch_elems[tsa_pkg::PITCH_W-1:tsa_pkg::TILE_SHIFT];
      if (cfg.tile_mode) begin
         row     = tile_y >> cfg.cbits;
         col     = tile_x >> cfg.bbits;
         per_row = pitch_tiles >> cfg.bbits;
      end else begin
         row     = tile_y;
         col     = tile_x;
         per_row = pitch_tiles;
      end
      row_prod   = PROD_W'(row) * PROD_W'(per_row);
      tile_index = {1'b0, row_prod} + IDX_W'(col);
   end

   // Element order inside a micro tile
   always_comb begin
      pn_depth = {pixel_y[2], pixel_x[2], pixel_y[1], pixel_x[1], pixel_y[0], pixel_x[0]};
      case (cfg.elem_size)
         tsa_pkg::EB_1:  pn_color = {pixel_y[2], pixel_y[0], pixel_y[1],
                                     pixel_x[2], pixel_x[1], pixel_x[0]};
         tsa_pkg::EB_2:  pn_color = {pixel_y[2], pixel_y[1], pixel_y[0],
                                     pixel_x[2], pixel_x[1], pixel_x[0]};
         tsa_pkg::EB_4:  pn_color = {pixel_y[2], pixel_y[1], pixel_x[2],
                                     pixel_y[0], pixel_x[1], pixel_x[0]};
         tsa_pkg::EB_8:  pn_color = {pixel_y[2], pixel_y[1], pixel_x[2],
                                     pixel_x[1], pixel_y[0], pixel_x[0]};
         tsa_pkg::EB_16: pn_color = {pixel_y[2], pixel_y[1], pixel_x[2],
                                     pixel_x[1], pixel_x[0], pixel_y[0]};
         default:        pn_color = '0;
      endcase
      color_off = tsa_pkg::ELEM_OFF_W'(pn_color) * tsa_pkg::ELEM_OFF_W'(cfg.elem_size);

      // 4-byte depth: stencil bytes first, then 3-byte depth values
      dz = tsa_pkg::ELEM_OFF_W'(pn_depth);
      case (cfg.elem_size)
         tsa_pkg::EB_2: depth_off = dz << 1;
         tsa_pkg::EB_4: depth_off = stencil_plane ? dz :
                           dz + (dz << 1) +
                           tsa_pkg::ELEM_OFF_W'(tsa_pkg::STENCIL_PLANE_BYTES);
         default:       depth_off = '0;
      endcase
      elem_off = depth_surface ? depth_off : color_off;
   end

   // Channel and bank swizzles; bank y bits sit above the channel bits
   always_comb begin
      y_sh = pixel_y >> cfg.cbits;
      alt4 = cfg.alt_bank_swizzle & pixel_x[5];
      alt8 = cfg.alt_bank_swizzle & pixel_x[6];
      case (cfg.chan_count)
         tsa_pkg::CH_4: chan_sel = {1'b0, pixel_x[3] ^ pixel_y[4],
                                    pixel_x[4] ^ pixel_y[3]};
         tsa_pkg::CH_8: chan_sel = {pixel_x[3] ^ pixel_y[5],
                                    pixel_x[4] ^ pixel_x[5] ^ pixel_y[4],
                                    pixel_x[5] ^ pixel_y[3]};
         default:       chan_sel = {2'b00, pixel_x[3] ^ pixel_y[3]};
      endcase
      case (cfg.bank_count)
         tsa_pkg::BK_4: bank_sel = {1'b0, pixel_x[4] ^ y_sh[3] ^ alt4,
                                    pixel_x[3] ^ y_sh[4]};
         tsa_pkg::BK_8: bank_sel = {pixel_x[5] ^ y_sh[3] ^ alt8,
                                    pixel_x[4] ^ y_sh[4] ^ y_sh[5],
                                    pixel_x[3] ^ y_sh[5]};
         default:       bank_sel = '0;
      endcase
   end

   assign place = {elem_off, chan_sel, bank_sel};

endmodule

// ===== rtl/tsa_merge.sv =====
// Macro tiles: offset split at the group boundary, channel/bank bits inserted.
module tsa_merge (
   input  tsa_pkg::cfg_type            cfg,
   input  logic [tsa_pkg::OFF_W-1:0]   total,
   input  tsa_pkg::place_type          place,
   output logic [tsa_pkg::OFF_W-1:0]   byte_offset
);

   logic [tsa_pkg::OFF_W-1:0]     gmask, low, high, chan_term, bank_term;
   logic [tsa_pkg::SWZ_W-1:0]     swz_sh;
   logic [tsa_pkg::LOG_W-1:0]     bank_sh;

   always_comb begin
      swz_sh    = {1'b0, cfg.cbits} + {1'b0, cfg.bbits};
      bank_sh   = cfg.gbits + {2'b00, cfg.cbits};
      gmask     = (tsa_pkg::OFF_W'(1) << cfg.gbits) - tsa_pkg::OFF_W'(1);
      low       = total & gmask;
      high      = (total & ~gmask) << swz_sh;
      chan_term = tsa_pkg::OFF_W'(place.channel) << cfg.gbits;
      bank_term = tsa_pkg::OFF_W'(place.bank) << bank_sh;
      // terms can overlap for degenerate channel counts, so add rather than OR
      byte_offset = cfg.tile_mode ? (bank_term + chan_term + low + high) : total;
   end

endmodule

// ===== rtl/tiled_surface_address_core.sv =====
// Channel | Dir | Fields
// req_ch  | in  | pixel_x, pixel_y (COORD_BITS), depth_surface, stencil_plane
// rsp_ch  | out | byte_offset (32)
// csr_*   | in  | csr_we, csr_index (3), csr_wdata (18), write only
//
// One item per cycle unless rsp_ch stalls; an accepted item passes every register stage below to rsp_ch.
// Four register stages: input, tile index product, linear offset, result.
// The row x pitch and index x tile bytes products sit in separate stages.
// reset (synchronous) empties the pipe and loads the register defaults.
// rsp_ch.ready low holds the result; up to four items queue before req_ch.ready drops.
module tiled_surface_address_core #(
   parameter int COORD_BITS = tsa_pkg::COORD_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   tsa_req_if.sink                         req_ch,
   tsa_rsp_if.source                       rsp_ch,
   input  logic                            csr_we,
   input  logic [tsa_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [tsa_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   localparam int IDX_W  = COORD_BITS - tsa_pkg::TILE_SHIFT + tsa_pkg::PERROW_W + 1;
   localparam int PROD_W = IDX_W + tsa_pkg::TILE_BYTES_W;

   tsa_pkg::cfg_type cfg;

   tsa_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // pipe flow: a stage takes a new item when empty or when it moves on
   logic rdy1, rdy2, rdy3, rdy_o;
   logic v1_ff, v2_ff, v3_ff, vo_ff;
   logic v1_in, v2_in, v3_in, vo_in;

   assign rdy_o = !vo_ff || rsp_ch.ready;
   assign rdy3  = !v3_ff || rdy_o;
   assign rdy2  = !v2_ff || rdy3;
   assign rdy1  = !v1_ff || rdy2;
   assign req_ch.ready = rdy1;

   assign v1_in = rdy1  ? req_ch.valid : v1_ff;
   assign v2_in = rdy2  ? v1_ff : v2_ff;
   assign v3_in = rdy3  ? v2_ff : v3_ff;
   assign vo_in = rdy_o ? v3_ff : vo_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         vo_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
         vo_ff <= vo_in;
      end
   end

   // Input stage
   logic [COORD_BITS-1:0] x1_ff, y1_ff, x1_in, y1_in;
   logic                  dep1_ff, sten1_ff, dep1_in, sten1_in;

   assign x1_in    = rdy1 ? req_ch.pixel_x       : x1_ff;
   assign y1_in    = rdy1 ? req_ch.pixel_y       : y1_ff;
   assign dep1_in  = rdy1 ? req_ch.depth_surface : dep1_ff;
   assign sten1_in = rdy1 ? req_ch.stencil_plane : sten1_ff;

   always_ff @(posedge clock) begin
      x1_ff    <= x1_in;
      y1_ff    <= y1_in;
      dep1_ff  <= dep1_in;
      sten1_ff <= sten1_in;
   end

   // Tile index and in-tile placement
   logic [IDX_W-1:0]   idx_a;
   tsa_pkg::place_type place_a;

   tsa_geom #(.COORD_BITS(COORD_BITS)) u_geom (
      .cfg           (cfg),
      .pixel_x       (x1_ff),
      .pixel_y       (y1_ff),
      .depth_surface (dep1_ff),
      .stencil_plane (sten1_ff),
      .tile_index    (idx_a),
      .place         (place_a)
   );

   logic [IDX_W-1:0]   idx2_ff, idx2_in;
   tsa_pkg::place_type place2_ff, place2_in;

   assign idx2_in   = rdy2 ? idx_a   : idx2_ff;
   assign place2_in = rdy2 ? place_a : place2_ff;

   always_ff @(posedge clock) begin
      idx2_ff   <= idx2_in;
      place2_ff <= place2_in;
   end

   // Linear byte offset, kept modulo 2^32
   logic [tsa_pkg::TILE_BYTES_W-1:0] tile_size;
   logic [PROD_W-1:0]                tile_prod;
   logic [tsa_pkg::OFF_W-1:0]        total_b;

   assign tile_size = {cfg.elem_size, {tsa_pkg::TILE_AREA_SHIFT{1'b0}}};
   assign tile_prod = PROD_W'(idx2_ff) * PROD_W'(tile_size);
   assign total_b   = tsa_pkg::OFF_W'(tile_prod) + tsa_pkg::OFF_W'(place2_ff.elem_off);

   logic [tsa_pkg::OFF_W-1:0] total3_ff, total3_in;
   tsa_pkg::place_type        place3_ff, place3_in;

   assign total3_in = rdy3 ? total_b   : total3_ff;
   assign place3_in = rdy3 ? place2_ff : place3_ff;

   always_ff @(posedge clock) begin
      total3_ff <= total3_in;
      place3_ff <= place3_in;
   end

   // Final address
   logic [tsa_pkg::OFF_W-1:0] offset_c;

   tsa_merge u_merge (
      .cfg         (cfg),
      .total       (total3_ff),
      .place       (place3_ff),
      .byte_offset (offset_c)
   );

   logic [tsa_pkg::OFF_W-1:0] out_ff, out_in;

   assign out_in = rdy_o ? offset_c : out_ff;

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   assign rsp_ch.valid       = vo_ff;
   assign rsp_ch.byte_offset = out_ff;

endmodule

// ===== rtl/tsa_checker.sv =====
`include "assert_macros.svh"

module tsa_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [tsa_pkg::OFF_W-1:0]   rsp_byte_offset
);

   // nothing comes out in the cycle after reset
   `TSA_ASSERT_ALWAYS(a_reset_empty, clock, $past(reset) |-> !rsp_valid, "result valid after reset")

   // an empty result register means the whole pipe can take an item
   `TSA_ASSERT(a_empty_takes, clock, reset, !rsp_valid |-> req_ready, "input blocked with empty output")

   // with the output draining, an accepted item passes the input, tile index, offset and result registers and comes out
   `TSA_ASSERT(a_latency, clock, reset, req_valid && req_ready ##1 rsp_ready ##1 rsp_ready ##1 rsp_ready |=> rsp_valid, "item lost or late in pipe")

   `TSA_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_byte_offset), "stalled result changed")

endmodule

bind tiled_surface_address_core tsa_checker u_tsa_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_ch.valid),
   .req_ready       (req_ch.ready),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_byte_offset (rsp_ch.byte_offset)
);

// ===== dv/tiled_surface_address_core_test.sv =====
`timescale 1ns / 1ps

module tiled_surface_address_core_test;
   import tsa_pkg::*;

   localparam int XY_W       = COORD_BITS_DEF;
   localparam int LATENCY    = 3;
   localparam int HOLD_LEN   = 100;
   localparam int TIMEOUT_NS = 2_000_000;

   localparam logic MODE_MICRO = 1'b0;
   localparam logic MODE_MACRO = 1'b1;

   typedef enum int {RX_STREAM, RX_COIN, RX_MOSTLY, RX_SPARSE} rx_pattern_type;

   typedef struct {
      logic [XY_W-1:0]  x;
      logic [XY_W-1:0]  y;
      logic             depth;
      logic             stencil;
      logic [OFF_W-1:0] offset;
   } addr_expect_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_we;
   csr_index_type csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   tsa_req_if #(.COORD_BITS(XY_W)) req_bus ();
   tsa_rsp_if rsp_bus ();

   tiled_surface_address_core #(.COORD_BITS(XY_W)) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_bus),
      .rsp_ch    (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // shadow of the register file
   logic                cfg_tile_mode;
   logic [EB_W-1:0]     cfg_elem_bytes;
   logic [PITCH_W-1:0]  cfg_pitch;
   logic [GROUP_W-1:0]  cfg_group;
   logic [CHAN_W-1:0]   cfg_channels;
   logic [BANK_W-1:0]   cfg_banks;
   logic                cfg_alt_swz;

   addr_expect_type pending_offsets[$];
   addr_expect_type oldest_addr;
   int fail_count = 0;

   // sender burst state
   int  burst_left = 0;
   bit  gaps_on = 1'b1;

   // receiver state
   int hold_req = 0;
   int hold_ack = 0;
   int hold_left = 0;
   int mode_left = 0;
   rx_pattern_type rx_mode = RX_STREAM;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("tiled_surface_address_core regression: fail");
      $finish;
   end

   function automatic int unsigned size_log2(input logic [31:0] v);
      int unsigned r;
      logic [31:0] rest;
      r = 0;
      rest = v;
      while (rest > 1) begin
         rest = rest >> 1;
         r++;
      end
      return r;
   endfunction

   function automatic logic [OFF_W-1:0] tiled_offset_of(input logic [XY_W-1:0] x,
                                                        input logic [XY_W-1:0] y,
                                                        input logic depth,
                                                        input logic stencil);
      logic [5:0] pn;
      logic [2:0] channel;
      logic [2:0] bank;
      logic [63:0] elem_off, tile_size, pitch_elems, tile_idx;
      logic [63:0] mt_per_row, mt_bytes, mt_row, mt_col;
      logic [63:0] total, gmask, low, high, result;
      int unsigned gb, cb, bb;

      tile_size   = 64'(cfg_elem_bytes) << TILE_AREA_SHIFT;
      pitch_elems = 64'(cfg_pitch) >> size_log2(32'(cfg_elem_bytes));

      if (depth) begin
         // Morton order; 4-byte depth splits into stencil bytes then 3-byte depth
         pn = {y[2], x[2], y[1], x[1], y[0], x[0]};
         if (cfg_elem_bytes == EB_2) elem_off = 64'(pn) * 2;
         else if (cfg_elem_bytes == EB_4)
            elem_off = stencil ? 64'(pn) : 64'(pn) * 3 + STENCIL_PLANE_BYTES;
         else elem_off = '0;
      end else begin
         case (cfg_elem_bytes)
            EB_1:    pn = {y[2], y[0], y[1], x[2], x[1], x[0]};
            EB_2:    pn = {y[2], y[1], y[0], x[2], x[1], x[0]};
            EB_4:    pn = {y[2], y[1], x[2], y[0], x[1], x[0]};
            EB_8:    pn = {y[2], y[1], x[2], x[1], y[0], x[0]};
            EB_16:   pn = {y[2], y[1], x[2], x[1], x[0], y[0]};
            default: pn = '0;
         endcase
         elem_off = 64'(pn) * cfg_elem_bytes;
      end

      if (cfg_tile_mode == MODE_MICRO) begin
         tile_idx = 64'(y >> TILE_SHIFT) * (pitch_elems >> TILE_SHIFT) + 64'(x >> TILE_SHIFT);
         result   = tile_idx * tile_size + elem_off;
      end else begin
         gb = size_log2(32'(cfg_group));
         cb = size_log2(32'(cfg_channels));
         bb = size_log2(32'(cfg_banks));
         gmask = (64'd1 << gb) - 1;

         if (cfg_channels == CH_4) channel = {1'b0, x[3] ^ y[4], x[4] ^ y[3]};
         else if (cfg_channels == CH_8)
            channel = {x[3] ^ y[5], x[4] ^ x[5] ^ y[4], x[5] ^ y[3]};
         else channel = {2'b00, x[3] ^ y[3]};

         if (cfg_banks == BK_4)
            bank = {1'b0, x[4] ^ y[3+cb] ^ (cfg_alt_swz & x[5]), x[3] ^ y[4+cb]};
         else if (cfg_banks == BK_8)
            bank = {x[5] ^ y[3+cb] ^ (cfg_alt_swz & x[6]),
                    x[4] ^ y[4+cb] ^ y[5+cb],
                    x[3] ^ y[5+cb]};
         else bank = '0;

         mt_per_row = (pitch_elems >> TILE_SHIFT) >> bb;
         mt_bytes   = tile_size << (bb + cb);
         mt_row     = 64'(y >> TILE_SHIFT) >> cb;
         mt_col     = 64'(x >> TILE_SHIFT) >> bb;
         total      = ((mt_row * mt_per_row + mt_col) * mt_bytes) >> (cb + bb);
         total      = total + elem_off;
         low        = total & gmask;
         // channel and bank bits go in just above the group bits
         high       = (total & ~gmask) << (cb + bb);
         result     = (64'(bank) << (gb + cb)) + (64'(channel) << gb) + low + high;
      end
      return result[OFF_W-1:0];
   endfunction

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_offsets.size() == 0) begin
            $error("byte_offset: expected none, actual %h", rsp_bus.byte_offset);
            fail_count++;
         end else begin
            oldest_addr = pending_offsets.pop_front();
            if (rsp_bus.byte_offset !== oldest_addr.offset) begin
               $error("byte_offset: expected %h, actual %h (x %0d y %0d depth %0b stencil %0b)",
                      oldest_addr.offset, rsp_bus.byte_offset, oldest_addr.x, oldest_addr.y,
                      oldest_addr.depth, oldest_addr.stencil);
               fail_count++;
            end
         end
      end
   end

   // receiver: own stall pattern plus an occasional long hold
   always @(negedge clock) begin
      if (hold_req != hold_ack) begin
         hold_ack  = hold_req;
         hold_left = HOLD_LEN;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_bus.ready = 1'b0;
      end else begin
         if (mode_left == 0) begin
            rx_mode   = rx_pattern_type'($urandom_range(0, 3));
            mode_left = $urandom_range(16, 96);
         end
         mode_left--;
         case (rx_mode)
            RX_STREAM: rsp_bus.ready = 1'b1;
            RX_COIN:   rsp_bus.ready = 1'($urandom_range(0, 1));
            RX_MOSTLY: rsp_bus.ready = ($urandom_range(0, 7) != 0);
            default:   rsp_bus.ready = ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   task automatic send_pixel(input logic [XY_W-1:0] x, input logic [XY_W-1:0] y,
                             input logic depth, input logic stencil);
      addr_expect_type item;
      if (gaps_on && burst_left <= 0) begin
         @(negedge clock);
         req_bus.valid = 1'b0;
         repeat ($urandom_range(0, 5)) @(negedge clock);
         burst_left = $urandom_range(1, 20);
      end
      burst_left--;
      @(negedge clock);
      req_bus.valid         = 1'b1;
      req_bus.pixel_x       = x;
      req_bus.pixel_y       = y;
      req_bus.depth_surface = depth;
      req_bus.stencil_plane = stencil;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      item.x       = x;
      item.y       = y;
      item.depth   = depth;
      item.stencil = stencil;
      item.offset  = tiled_offset_of(x, y, depth, stencil);
      pending_offsets.push_back(item);
   endtask

   task automatic wait_quiet();
      @(negedge clock);
      req_bus.valid = 1'b0;
      while (pending_offsets.size() != 0) @(posedge clock);
      repeat (LATENCY + 2) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      case (idx)
         CSR_TILE_MODE:        cfg_tile_mode  = data[0];
         CSR_ELEM_SIZE:        cfg_elem_bytes = data[EB_W-1:0];
         CSR_PITCH_BYTES:      cfg_pitch      = data[PITCH_W-1:0];
         CSR_GROUP_BYTES:      cfg_group      = data[GROUP_W-1:0];
         CSR_CHAN_COUNT:       cfg_channels   = data[CHAN_W-1:0];
         CSR_BANK_COUNT:       cfg_banks      = data[BANK_W-1:0];
         CSR_ALT_BANK_SWIZZLE: cfg_alt_swz    = data[0];
         default: ;
      endcase
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   task automatic set_config(input logic tm, input logic [EB_W-1:0] eb,
                             input logic [PITCH_W-1:0] pitch, input logic [GROUP_W-1:0] group,
                             input logic [CHAN_W-1:0] ch, input logic [BANK_W-1:0] bk,
                             input logic alt);
      wait_quiet();
      write_reg(CSR_TILE_MODE, CSR_DATA_W'(tm));
      write_reg(CSR_ELEM_SIZE, CSR_DATA_W'(eb));
      write_reg(CSR_PITCH_BYTES, CSR_DATA_W'(pitch));
      write_reg(CSR_GROUP_BYTES, CSR_DATA_W'(group));
      write_reg(CSR_CHAN_COUNT, CSR_DATA_W'(ch));
      write_reg(CSR_BANK_COUNT, CSR_DATA_W'(bk));
      write_reg(CSR_ALT_BANK_SWIZZLE, CSR_DATA_W'(alt));
   endtask

   task automatic randomize_config();
      logic [EB_W-1:0]    eb;
      logic [PITCH_W-1:0] pitch;
      logic [GROUP_W-1:0] group;
      logic [CHAN_W-1:0]  ch;
      logic [BANK_W-1:0]  bk;
      int sel;

      if ($urandom_range(0, 4) != 0) eb = EB_W'(1 << $urandom_range(0, 4));
      else eb = EB_W'($urandom_range(0, 31));

      sel = $urandom_range(0, 5);
      if (sel == 0) pitch = PITCH_W'($urandom_range(0, 262143));
      else if (sel == 1) pitch = (sel == 1 && $urandom_range(0, 1)) ? '1 : '0;
      else pitch = PITCH_W'(1 << $urandom_range(6, 17));

      if ($urandom_range(0, 6) != 0) group = GROUP_W'(1 << $urandom_range(6, 10));
      else group = GROUP_W'($urandom_range(0, 2047));

      sel = $urandom_range(0, 7);
      if (sel < 7) ch = CHAN_W'(2 << (sel % 3));
      else ch = CHAN_W'($urandom_range(0, 15));

      sel = $urandom_range(0, 7);
      if (sel < 7) bk = (sel % 2) ? BK_8 : BK_4;
      else bk = BANK_W'($urandom_range(0, 15));

      set_config(1'($urandom_range(0, 1)), eb, pitch, group, ch, bk,
                 1'($urandom_range(0, 1)));
   endtask

   task automatic send_random_pixel();
      logic [XY_W-1:0] x, y;
      case ($urandom_range(0, 3))
         0: begin
            x = XY_W'($urandom_range(0, 63));
            y = XY_W'($urandom_range(0, 63));
         end
         1: begin
            x = ~XY_W'($urandom_range(0, 63));
            y = ~XY_W'($urandom_range(0, 63));
         end
         default: begin
            x = XY_W'($urandom);
            y = XY_W'($urandom);
         end
      endcase
      send_pixel(x, y, ($urandom_range(0, 4) < 2), 1'($urandom_range(0, 1)));
   endtask

   task automatic test_reset_defaults();
      send_pixel('0, '0, 1'b0, 1'b0);
      send_pixel('1, '1, 1'b0, 1'b0);
      send_pixel('1, '1, 1'b1, 1'b1);
      send_pixel(14'h2AAA, 14'h1555, 1'b1, 1'b0);
   endtask

   task automatic test_micro_tiling();
      logic [EB_W-1:0] sizes[4];
      sizes = '{EB_1, EB_2, EB_8, EB_16};
      foreach (sizes[i]) begin
         set_config(MODE_MICRO, sizes[i], 18'd2048, 11'd256, 4'd2, BK_4, 1'b0);
         send_pixel(XY_W'(i * 37 + 13), XY_W'(i * 91 + 27), 1'b0, 1'b0);
      end
      // 4-byte depth: stencil plane and depth plane
      set_config(MODE_MICRO, EB_4, 18'd4096, 11'd256, 4'd2, BK_4, 1'b0);
      send_pixel(14'd63, 14'd45, 1'b1, 1'b1);
      send_pixel(14'd63, 14'd45, 1'b1, 1'b0);
   endtask

   task automatic test_macro_tiling();
      logic [CHAN_W-1:0] chans[3];
      chans = '{4'd2, CH_4, CH_8};
      for (int k = 0; k < 6; k++) begin
         set_config(MODE_MACRO, EB_4, 18'd8192, 11'd512, chans[k % 3],
                    (k < 3) ? BK_4 : BK_8, 1'(k % 2));
         send_pixel(14'h1A5F ^ XY_W'(k * 14'h0731), 14'h2C3B ^ XY_W'(k * 14'h05E9),
                    1'b0, 1'b0);
      end
   endtask

   task automatic test_odd_sizes();
      // all size registers zero
      set_config(MODE_MACRO, 5'd0, 18'd0, 11'd0, 4'd0, 4'd0, 1'b0);
      send_pixel('1, '1, 1'b0, 1'b0);
      // largest register values; depth with an odd element size
      set_config(MODE_MACRO, 5'd31, '1, '1, 4'd15, 4'd15, 1'b1);
      send_pixel('1, '1, 1'b1, 1'b1);
      set_config(MODE_MICRO, 5'd3, '1, 11'd100, 4'd1, 4'd2, 1'b1);
      send_pixel(14'd9000, '1, 1'b0, 1'b0);
      set_config(MODE_MACRO, EB_4, '1, 11'd1024, CH_8, BK_8, 1'b1);
      send_pixel('1, '1, 1'b1, 1'b1);
      // stencil flag without depth is ignored
      set_config(MODE_MACRO, 5'd12, 18'd6000, 11'd64, 4'd6, 4'd5, 1'b0);
      send_pixel(14'd777, 14'd5000, 1'b0, 1'b1);
      set_config(MODE_MICRO, EB_8, 18'd4096, 11'd256, CH_4, BK_4, 1'b0);
      send_pixel(14'd4321, 14'd1234, 1'b1, 1'b0);
   endtask

   task automatic test_backpressure();
      set_config(MODE_MACRO, EB_4, 18'd4096, 11'd256, CH_4, BK_8, 1'b1);
      gaps_on = 1'b0;
      hold_req++;
      repeat (40) send_random_pixel();
      gaps_on = 1'b1;
   endtask

   task automatic test_random();
      for (int phase = 0; phase < 16; phase++) begin
         randomize_config();
         gaps_on = ($urandom_range(0, 3) != 0);
         repeat (22) send_random_pixel();
      end
      gaps_on = 1'b1;
   endtask

   initial begin
      reset                 = 1'b1;
      csr_we                = 1'b0;
      csr_index             = CSR_TILE_MODE;
      csr_wdata             = '0;
      req_bus.valid         = 1'b0;
      req_bus.pixel_x       = '0;
      req_bus.pixel_y       = '0;
      req_bus.depth_surface = 1'b0;
      req_bus.stencil_plane = 1'b0;
      rsp_bus.ready         = 1'b0;
      cfg_tile_mode         = RST_TILE_MODE;
      cfg_elem_bytes        = RST_ELEM_BYTES;
      cfg_pitch             = RST_PITCH_BYTES;
      cfg_group             = RST_GROUP_BYTES;
      cfg_channels          = RST_NUM_CHAN;
      cfg_banks             = RST_NUM_BANKS;
      cfg_alt_swz           = RST_ALT_SWZ;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_defaults();
      test_micro_tiling();
      test_macro_tiling();
      test_odd_sizes();
      test_backpressure();
      test_random();

      wait_quiet();
      if (fail_count == 0) begin
         $display("tiled_surface_address_core regression: pass");
      end else begin
         $display("tiled_surface_address_core regression: fail");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/tsa_pkg.sv
rtl/tsa_if.sv
rtl/tsa_csr.sv
rtl/tsa_geom.sv
rtl/tsa_merge.sv
rtl/tiled_surface_address_core.sv
rtl/tsa_checker.sv
dv/tiled_surface_address_core_test.sv
